/* rtl/sst_pkg.sv */
// Shared types and constants of the scoped symbol table.
// Used by the channel interfaces and the top level; depends on nothing.
package sst_pkg;

    localparam int KEY_W   = 32;
    localparam int KIND_W  = 32;
    localparam int PLACE_W = 32;
    localparam int ENTRY_W = KEY_W + KIND_W + PLACE_W;

    typedef enum logic [1:0] {
        FN_OPEN    = 2'd0,
        FN_CLOSE   = 2'd1,
        FN_DECLARE = 2'd2,
        FN_LOOKUP  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_SCOPE_FULL = 2'd1,
        STAT_AT_GLOBAL  = 2'd2,
        STAT_STORE_FULL = 2'd3
    } status_t;

    typedef struct packed {
        status_t              status;
        logic                 found;
        logic [KIND_W-1:0]    kind;
        logic [PLACE_W-1:0]   place;
    } result_t;

endpackage

/* rtl/sst_in_if.sv */
// Request channel of the scoped symbol table: valid, ready and one operation.
// Depends on sst_pkg.
interface sst_in_if;
    import sst_pkg::*;

    logic               valid;
    logic               ready;
    func_t              func;
    logic [KEY_W-1:0]   key;
    logic [KIND_W-1:0]  node_kind;
    logic [PLACE_W-1:0] source_place;

    modport source (output valid, func, key, node_kind, source_place, input ready);
    modport sink   (input valid, func, key, node_kind, source_place, output ready);
endinterface

/* rtl/sst_out_if.sv */
// Result channel of the scoped symbol table: valid, ready and one result.
// Depends on sst_pkg.
interface sst_out_if;
    import sst_pkg::*;

    logic               valid;
    logic               ready;
    status_t            status;
    logic               found;
    logic [KIND_W-1:0]  found_kind;
    logic [PLACE_W-1:0] found_place;

    modport source (output valid, status, found, found_kind, found_place, input ready);
    modport sink   (input valid, status, found, found_kind, found_place, output ready);
endinterface

/* rtl/scoped_symbol_table.sv */
// Scoped symbol table: an entry stack and a scope-start stack, both in RAM,
// with a sequencer that scans the entry stack one entry per cycle on lookup.
// Depends on sst_pkg, sst_in_if, sst_out_if and sst_ram.
//
//   Channel | Direction | Beat contents
//   --------+-----------+----------------------------------------------
//   req     | in        | func, key, node_kind, source_place
//   rsp     | out       | status, found, found_kind, found_place
//
// One request is taken at a time; req.ready is high only while the sequencer
// is idle. Open, declare and every rejected operation pass from idle through
// the push state back to idle; close passes through the close state first, as
// the saved scope start comes back from the scope RAM's registered read port.
// A lookup of a non-empty table also scans, the single key comparator walking
// the entry RAM from newest to oldest until a hit or the oldest entry.
// The push state waits while rsp still holds an unaccepted result. The result
// sits in an output register, so the next request is accepted as soon as the
// sequencer has handed its result over, even if rsp is stalled.
// Reset clears the state, the output valid, the entry count and the scope level;
// the RAMs need no clearing pass because nothing at or above either stack pointer is ever used.
module scoped_symbol_table #(
    parameter int ENTRY_DEPTH = 64,
    parameter int SCOPE_SLOTS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    sst_in_if.sink           req,
    sst_out_if.source        rsp
);
    import sst_pkg::*;

    // Count and level must hold the depth itself; indexes need only the depth.
    localparam int CW  = $clog2(ENTRY_DEPTH + 1);
    localparam int IW  = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
    localparam int LW  = $clog2(SCOPE_SLOTS + 1);
    localparam int SIW = (SCOPE_SLOTS > 1) ? $clog2(SCOPE_SLOTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CLOSE = 4'b0010,
        S_SCAN  = 4'b0100,
        S_PUSH  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [LW-1:0]      level_reg, level_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    result_t            res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_res_reg, out_res_next;

    logic               req_fire;
    logic [CW-1:0]      cnt_m1;
    logic [LW-1:0]      lvl_m1;
    logic [IW-1:0]      idx_m1;

    logic               ent_we;
    logic [IW-1:0]      ent_raddr;
    logic [ENTRY_W-1:0] ent_wdata;
    logic [ENTRY_W-1:0] ent_rdata;
    logic               scope_we;
    logic [CW-1:0]      scope_rdata;

    assign req_fire = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign cnt_m1 = count_reg - CW'(1);
    assign lvl_m1 = level_reg - LW'(1);
    assign idx_m1 = idx_reg - IW'(1);

    // An entry is stored as key, node kind and source place, key uppermost.
    assign ent_wdata = {req.key, req.node_kind, req.source_place};

    sst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRY_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (count_reg[IW-1:0]),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // Each open scope remembers the entry count at the moment it was opened.
    sst_ram #(
        .WIDTH (CW),
        .DEPTH (SCOPE_SLOTS)
    ) u_scope_ram (
        .clk   (clk),
        .we    (scope_we),
        .waddr (level_reg[SIW-1:0]),
        .wdata (count_reg),
        .raddr (lvl_m1[SIW-1:0]),
        .rdata (scope_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        level_next     = level_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_res_next   = out_res_reg;
        ent_we         = 1'b0;
        scope_we       = 1'b0;
        ent_raddr      = idx_m1;

        case (state_reg)
            S_IDLE:
            begin
                // Point the entry RAM at the newest entry so that a lookup
                // has its first candidate ready in the following cycle.
                ent_raddr = cnt_m1[IW-1:0];
                if (req_fire)
                begin
                    res_next = '{status: STAT_OK, found: 1'b0, kind: '0, place: '0};
                    state_next = S_PUSH;
                    case (req.func)
                        FN_OPEN:
                        begin
                            if (level_reg == LW'(SCOPE_SLOTS))
                            begin
                                res_next.status = STAT_SCOPE_FULL;
                            end
                            else
                            begin
                                scope_we   = 1'b1;
                                level_next = level_reg + LW'(1);
                            end
                        end
                        FN_CLOSE:
                        begin
                            if (level_reg == '0)
                            begin
                                res_next.status = STAT_AT_GLOBAL;
                            end
                            else
                            begin
                                level_next = lvl_m1;
                                state_next = S_CLOSE;
                            end
                        end
                        FN_DECLARE:
                        begin
                            if (count_reg == CW'(ENTRY_DEPTH))
                            begin
                                res_next.status = STAT_STORE_FULL;
                            end
                            else
                            begin
                                ent_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FN_LOOKUP:
                        begin
                            key_next = req.key;
                            if (count_reg != '0)
                            begin
                                idx_next   = cnt_m1[IW-1:0];
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_PUSH;
                        end
                    endcase
                end
            end

            S_CLOSE:
            begin
                // The scope RAM now returns the count saved when this scope opened.
                count_next = scope_rdata;
                state_next = S_PUSH;
            end

            S_SCAN:
            begin
                // ent_rdata holds entry idx_reg; the next older one is fetched
                // in parallel so that one entry is compared every cycle.
                if (ent_rdata[ENTRY_W-1 -: KEY_W] == key_reg)
                begin
                    res_next.found = 1'b1;
                    res_next.kind  = ent_rdata[PLACE_W +: KIND_W];
                    res_next.place = ent_rdata[PLACE_W-1:0];
                    state_next     = S_PUSH;
                end
                else if (idx_reg == '0)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    idx_next = idx_m1;
                end
            end

            S_PUSH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        key_reg     <= key_next;
        res_reg     <= res_next;
        out_res_reg <= out_res_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_res_reg.status;
    assign rsp.found       = out_res_reg.found;
    assign rsp.found_kind  = out_res_reg.kind;
    assign rsp.found_place = out_res_reg.place;

    // Neither stack pointer may ever pass its depth.
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CW'(ENTRY_DEPTH)) && (level_reg <= LW'(SCOPE_SLOTS)))
        else $error("stack pointer beyond its depth");

    // A declare that fits grows the entry stack by exactly one.
    a_declare_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.func == FN_DECLARE && count_reg != CW'(ENTRY_DEPTH))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("declare did not advance the entry count");

    // A hit is only ever reported together with a good status.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.found) |-> (rsp.status == STAT_OK))
        else $error("found reported with an error status");

    // A close at global scope leaves the scope level untouched.
    a_global_close: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.func == FN_CLOSE && level_reg == '0) |=> (level_reg == '0))
        else $error("close at global scope changed the level");
endmodule

/* rtl/sst_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
